@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the date shifter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising clk edge outside reset.
`define CDA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clk edge outside reset.
`define CDA_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define CDA_ASSERT(label, prop, msg)
`define CDA_NEVER(label, expr, msg)

`endif

`endif

@@ sv/cda_pkg.sv @@
// ---------------------------------------------------------------------------
// cda_pkg
// Widths, calendar constants and helper functions for the date shifter.
// ---------------------------------------------------------------------------
package cda_pkg;

    // Field widths of the words on both channels
    localparam int DAY_OFFSET_BITS = 17;
    localparam int YEAR_BITS       = 14;
    localparam int MONTH_BITS      = 4;
    localparam int DAY_BITS        = 5;
    localparam int ADD_YEAR_BITS   = 15;
    localparam int ADD_MONTH_BITS  = 11;

    // Working year: start plus offsets plus whole 400-year cycles of the day offset
    localparam int YEAR_W = (DAY_OFFSET_BITS > 26) ? DAY_OFFSET_BITS - 8 : 18;
    // Working day: offset plus a clamped day, and room for the cycle length
    localparam int DAY_W  = (DAY_OFFSET_BITS + 1 > 20) ? DAY_OFFSET_BITS + 1 : 20;

    // Calendar constants
    localparam int CYCLE_DAYS  = 146097;
    localparam int CYCLE_YEARS = 400;
    localparam int YEAR_MAX    = 9999;

    localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_BITS-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_BITS-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_BITS-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_BITS-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

    // Month normalization: t + 12*Q_BIAS is never negative, so
    // floor(t / 12) = floor((t + 12*Q_BIAS) / 12) - Q_BIAS.
    localparam int MONTH_SPAN = 12;
    localparam int Q_BIAS     = 87;
    // start_month + add_months - 1 + 12*Q_BIAS
    localparam int T_BIAS     = MONTH_SPAN * Q_BIAS - 1;
    localparam int T_W        = 12;
    localparam int Q_W        = 8;
    // floor(x / 12) = (x * RECIP12) >> RECIP_SHIFT for every x below 2^T_W/2
    localparam int RECIP_SHIFT = 16;
    localparam logic [12:0] RECIP12 = 13'(((1 << RECIP_SHIFT) + MONTH_SPAN - 1) / MONTH_SPAN);

    // Inverse of an odd constant modulo 2^64 by Newton steps
    function automatic logic [63:0] odd_inverse(input logic [63:0] d);
        logic [63:0] x;
        x = d;
        for (int i = 0; i < 5; i++) begin
            x = x * (64'd2 - d * x);
        end
        return x;
    endfunction

    // Divisibility by 25: n * INV25 (mod 2^YEAR_W) stays at or below DIV25_MAX
    localparam logic [YEAR_W-1:0] INV25     = YEAR_W'(odd_inverse(64'd25));
    localparam logic [YEAR_W-1:0] DIV25_MAX = YEAR_W'(((64'd1 << YEAR_W) - 64'd1) / 64'd25);

    // Length of a month, given whether its year is a leap year
    function automatic logic [DAY_BITS-1:0] days_in(input logic leap,
                                                    input logic [MONTH_BITS-1:0] month);
        logic [DAY_BITS-1:0] len;
        if (month == MONTH_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end
        else if (month inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
            len = 5'd30;
        end
        else begin
            len = 5'd31;
        end
        return len;
    endfunction

endpackage

@@ sv/cda_in_if.sv @@
// ---------------------------------------------------------------------------
// cda_in_if
// Request channel: a start date and signed year, month and day offsets.
// ---------------------------------------------------------------------------
interface cda_in_if import cda_pkg::*; ();

    logic                              valid;
    logic                              ready;
    logic        [YEAR_BITS-1:0]       start_year;
    logic        [MONTH_BITS-1:0]      start_month;
    logic        [DAY_BITS-1:0]        start_day;
    logic signed [ADD_YEAR_BITS-1:0]   add_years;
    logic signed [ADD_MONTH_BITS-1:0]  add_months;
    logic signed [DAY_OFFSET_BITS-1:0] add_days;

    modport source (
        output valid, start_year, start_month, start_day, add_years, add_months, add_days,
        input  ready
    );

    modport sink (
        input  valid, start_year, start_month, start_day, add_years, add_months, add_days,
        output ready
    );

endinterface

@@ sv/cda_out_if.sv @@
// ---------------------------------------------------------------------------
// cda_out_if
// Result channel: the shifted date and the year range flag.
// ---------------------------------------------------------------------------
interface cda_out_if import cda_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [YEAR_BITS-1:0]  result_year;
    logic [MONTH_BITS-1:0] result_month;
    logic [DAY_BITS-1:0]   result_day;
    logic                  out_of_range;

    modport source (
        output valid, result_year, result_month, result_day, out_of_range,
        input  ready
    );

    modport sink (
        input  valid, result_year, result_month, result_day, out_of_range,
        output ready
    );

endinterface

@@ sv/calendar_date_add.sv @@
// ---------------------------------------------------------------------------
// calendar_date_add
// Gregorian date shifter: adds years and months, clamps the day, then walks
// the day offset month by month.
// ---------------------------------------------------------------------------
// Takes one request word at a time and returns one result word for it. The
// work runs in a small sequencer around one day adder and one year adder:
// load, month normalize (reciprocal multiply by 1/12), leap update, clamp,
// add the day offset, strip whole 400-year cycles of 146097 days, then one
// month per step. Walking backward, each month needs a step and an add; at
// each year boundary the leap flag is recomputed in an extra leap update.
// The request side is ready only while the sequencer is idle; the result
// sits in an output register, so a new request is taken while the last
// result still waits. A year that ends above 9999 gives 9999-12-31, below 1
// gives 0001-01-01, both with out_of_range set.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module calendar_date_add import cda_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    cda_in_if.sink      dates,
    cda_out_if.source   shifted
);

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DIV      = 4'd1;
    localparam logic [3:0] S_MON      = 4'd2;
    localparam logic [3:0] S_LEAP     = 4'd3;
    localparam logic [3:0] S_CLAMP    = 4'd4;
    localparam logic [3:0] S_ADD      = 4'd5;
    localparam logic [3:0] S_CYC      = 4'd6;
    localparam logic [3:0] S_STEP     = 4'd7;
    localparam logic [3:0] S_BACK_ADD = 4'd8;
    localparam logic [3:0] S_FIN      = 4'd9;

    localparam logic signed [DAY_W-1:0]  CYCLE_POS = DAY_W'(CYCLE_DAYS);
    localparam logic signed [DAY_W-1:0]  CYCLE_NEG = -DAY_W'(CYCLE_DAYS);
    localparam logic signed [YEAR_W-1:0] YEARS_POS = YEAR_W'(CYCLE_YEARS);
    localparam logic signed [YEAR_W-1:0] YEARS_NEG = -YEAR_W'(CYCLE_YEARS);
    localparam logic signed [YEAR_W-1:0] YEAR_ONE  = YEAR_W'(1);
    localparam logic signed [YEAR_W-1:0] YEAR_TOP  = YEAR_W'(YEAR_MAX);

    logic        [3:0]                 state_reg, state_next;
    logic        [3:0]                 ret_reg, ret_next;
    logic signed [YEAR_W-1:0]          year_reg, year_next;
    logic        [MONTH_BITS-1:0]      month_reg, month_next;
    logic signed [DAY_W-1:0]           day_reg, day_next;
    logic signed [DAY_OFFSET_BITS-1:0] dd_reg, dd_next;
    logic        [T_W-1:0]             t_reg, t_next;
    logic        [Q_W-1:0]             q_reg, q_next;
    logic                              leap_reg, leap_next;

    logic                              out_valid_reg, out_valid_next;
    logic        [YEAR_BITS-1:0]       res_year_reg, res_year_next;
    logic        [MONTH_BITS-1:0]      res_month_reg, res_month_next;
    logic        [DAY_BITS-1:0]        res_day_reg, res_day_next;
    logic                              res_flag_reg, res_flag_next;

    // Shared arithmetic
    logic signed [DAY_W-1:0]           day_opd;
    logic signed [DAY_W-1:0]           day_sum;
    logic signed [YEAR_W-1:0]          year_opd;
    logic signed [YEAR_W-1:0]          year_sum;
    logic        [DAY_BITS-1:0]        len;
    logic signed [DAY_W-1:0]           len_s;
    logic                              dd_pos;
    logic                              dd_neg;
    logic                              day_pos;
    logic        [24:0]                div_prod;
    logic        [T_W-1:0]             q_times12;
    logic        [T_W-1:0]             t_rem;
    logic signed [Q_W:0]               q_off;
    logic        [YEAR_W-1:0]          year_abs;
    logic        [YEAR_W-1:0]          mul25;
    logic                              leap_calc;
    logic signed [12:0]                t_load;
    logic                              accept;
    logic                              out_free;

    assign accept   = dates.valid && dates.ready;
    assign out_free = !out_valid_reg || shifted.ready;

    assign dates.ready          = (state_reg == S_IDLE);
    assign shifted.valid        = out_valid_reg;
    assign shifted.result_year  = res_year_reg;
    assign shifted.result_month = res_month_reg;
    assign shifted.result_day   = res_day_reg;
    assign shifted.out_of_range = res_flag_reg;

    // Month length of the current year and month
    assign len     = days_in(leap_reg, month_reg);
    assign len_s   = DAY_W'($signed({1'b0, len}));
    assign dd_neg  = dd_reg[DAY_OFFSET_BITS-1];
    assign dd_pos  = !dd_neg && (dd_reg != '0);
    assign day_pos = !day_reg[DAY_W-1] && (day_reg != '0);

    // Month normalization by reciprocal multiply
    assign t_load    = 13'($signed({1'b0, dates.start_month})) + 13'(dates.add_months)
                     + 13'(T_BIAS);
    assign div_prod  = 25'(t_reg) * 25'(RECIP12);
    assign q_times12 = {1'b0, q_reg, 3'b000} + {2'b00, q_reg, 2'b00};
    assign t_rem     = t_reg - q_times12;
    assign q_off     = $signed({1'b0, q_reg}) - $signed((Q_W + 1)'(Q_BIAS));

    // Leap rule on |year|: divisible by 25 and 16, or not by 25 and by 4
    assign year_abs  = year_reg[YEAR_W-1] ? unsigned'(-year_reg) : unsigned'(year_reg);
    assign mul25     = year_abs * INV25;
    assign leap_calc = (mul25 <= DIV25_MAX) ? (year_abs[3:0] == 4'd0)
                                            : (year_abs[1:0] == 2'd0);

    // Pick the day and year operands for this step
    always_comb
    begin
        day_opd  = '0;
        year_opd = '0;
        case (state_reg)
            S_ADD:
            begin
                day_opd = DAY_W'(dd_reg);
            end
            S_CYC:
            begin
                if (day_reg > CYCLE_POS)
                begin
                    day_opd  = CYCLE_NEG;
                    year_opd = YEARS_POS;
                end
                else
                begin
                    day_opd  = CYCLE_POS;
                    year_opd = YEARS_NEG;
                end
            end
            S_STEP:
            begin
                day_opd  = -len_s;
                year_opd = dd_neg ? -YEAR_ONE : YEAR_ONE;
            end
            S_BACK_ADD:
            begin
                day_opd = len_s;
            end
            S_MON:
            begin
                year_opd = YEAR_W'(q_off);
            end
            default:
            begin
                day_opd  = '0;
                year_opd = '0;
            end
        endcase
    end

    assign day_sum  = day_reg + day_opd;
    assign year_sum = year_reg + year_opd;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        dd_next        = dd_reg;
        t_next         = t_reg;
        q_next         = q_reg;
        leap_next      = leap_reg;
        out_valid_next = out_valid_reg && !shifted.ready;
        res_year_next  = res_year_reg;
        res_month_next = res_month_reg;
        res_day_next   = res_day_reg;
        res_flag_next  = res_flag_reg;

        case (state_reg)
            S_IDLE:
            begin
                // Load a request word; day zero counts as day one
                if (accept)
                begin
                    year_next  = YEAR_W'($signed({1'b0, dates.start_year}))
                               + YEAR_W'(dates.add_years);
                    t_next     = t_load[T_W-1:0];
                    day_next   = (dates.start_day == '0) ? DAY_W'(1)
                                                         : DAY_W'({1'b0, dates.start_day});
                    dd_next    = dates.add_days;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                q_next     = div_prod[RECIP_SHIFT +: Q_W];
                state_next = S_MON;
            end
            S_MON:
            begin
                month_next = t_rem[MONTH_BITS-1:0] + 4'd1;
                year_next  = year_sum;
                ret_next   = S_CLAMP;
                state_next = S_LEAP;
            end
            S_LEAP:
            begin
                leap_next  = leap_calc;
                state_next = ret_reg;
            end
            S_CLAMP:
            begin
                if (day_reg > len_s)
                begin
                    day_next = len_s;
                end
                state_next = S_ADD;
            end
            S_ADD:
            begin
                day_next   = day_sum;
                state_next = S_CYC;
            end
            S_CYC:
            begin
                // Strip whole 400-year cycles; the leap flag is unchanged
                if ((day_reg > CYCLE_POS) || (day_reg <= CYCLE_NEG))
                begin
                    day_next  = day_sum;
                    year_next = year_sum;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (dd_pos)
                begin
                    // Advance one month while the day overruns it
                    if (day_reg <= len_s)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        day_next = day_sum;
                        if (month_reg == MONTH_DEC)
                        begin
                            month_next = MONTH_JAN;
                            year_next  = year_sum;
                            ret_next   = S_STEP;
                            state_next = S_LEAP;
                        end
                        else
                        begin
                            month_next = month_reg + 4'd1;
                        end
                    end
                end
                else if (dd_neg)
                begin
                    // Back up one month while the day is not positive
                    if (day_pos)
                    begin
                        state_next = S_FIN;
                    end
                    else if (month_reg == MONTH_JAN)
                    begin
                        month_next = MONTH_DEC;
                        year_next  = year_sum;
                        ret_next   = S_BACK_ADD;
                        state_next = S_LEAP;
                    end
                    else
                    begin
                        month_next = month_reg - 4'd1;
                        state_next = S_BACK_ADD;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_BACK_ADD:
            begin
                day_next   = day_sum;
                state_next = S_STEP;
            end
            S_FIN:
            begin
                // Hand the word over once the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (year_reg > YEAR_TOP)
                    begin
                        res_year_next  = YEAR_BITS'(YEAR_MAX);
                        res_month_next = MONTH_DEC;
                        res_day_next   = 5'd31;
                        res_flag_next  = 1'b1;
                    end
                    else if (year_reg < YEAR_ONE)
                    begin
                        res_year_next  = YEAR_BITS'(1);
                        res_month_next = MONTH_JAN;
                        res_day_next   = 5'd1;
                        res_flag_next  = 1'b1;
                    end
                    else
                    begin
                        res_year_next  = year_reg[YEAR_BITS-1:0];
                        res_month_next = month_reg;
                        res_day_next   = day_reg[DAY_BITS-1:0];
                        res_flag_next  = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and result registers
    always_ff @(posedge clk)
    begin
        year_reg      <= year_next;
        month_reg     <= month_next;
        day_reg       <= day_next;
        dd_reg        <= dd_next;
        t_reg         <= t_next;
        q_reg         <= q_next;
        leap_reg      <= leap_next;
        res_year_reg  <= res_year_next;
        res_month_reg <= res_month_next;
        res_day_reg   <= res_day_next;
        res_flag_reg  <= res_flag_next;
    end

    `CDA_ASSERT(a_accept_starts, accept |=> (state_reg == S_DIV), "accepted word did not start the divide step")
    `CDA_NEVER(a_month_legal, ((state_reg == S_STEP) || (state_reg == S_FIN) || (state_reg == S_CLAMP)) && ((month_reg == 4'd0) || (month_reg > MONTH_DEC)), "month left 1..12 after normalization")
    `CDA_ASSERT(a_day_settled, (state_reg == S_FIN) |-> (day_pos && (day_reg <= DAY_W'(31))), "final day outside 1..31")
    `CDA_ASSERT(a_result_legal, (shifted.valid && !shifted.out_of_range) |-> ((shifted.result_month != 4'd0) && (shifted.result_month <= MONTH_DEC) && (shifted.result_day != 5'd0) && (shifted.result_year != 14'd0)), "in-range result has an illegal date")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Gregorian date shifter.
// ---------------------------------------------------------------------------
// Sends request words on the dates channel and works out each shifted date
// inside the bench. Every result word is checked field by field against the
// oldest prediction still waiting. The run covers calendar corner cases, a
// long stall on the result side while requests keep coming, random dates
// with idle bursts on both channels, and a last random stretch with both
// channels always busy.
// ---------------------------------------------------------------------------
module tb_top;
    import cda_pkg::*;

    // Slowest correct run: about 1200 words, each with a full day walk (a
    // backward day offset needs a step and an add per month) plus an idle gap
    // on each side. Allow 300 ms.
    localparam longint LIMIT_NS          = 300_000_000;
    localparam int     DRAIN_CYCLES      = 3000;
    localparam int     LONG_STALL_CYCLES = 400;
    localparam int     MAX_REPORTS       = 40;
    localparam int     RANDOM_WORDS      = 1000;
    localparam int     STEADY_WORDS      = 130;

    typedef struct {
        logic        [YEAR_BITS-1:0]       start_year;
        logic        [MONTH_BITS-1:0]      start_month;
        logic        [DAY_BITS-1:0]        start_day;
        logic signed [ADD_YEAR_BITS-1:0]   add_years;
        logic signed [ADD_MONTH_BITS-1:0]  add_months;
        logic signed [DAY_OFFSET_BITS-1:0] add_days;
    } date_req_t;

    typedef struct {
        logic [YEAR_BITS-1:0]  result_year;
        logic [MONTH_BITS-1:0] result_month;
        logic [DAY_BITS-1:0]   result_day;
        logic                  out_of_range;
    } date_res_t;

    logic clk = 1'b0;
    logic rst_n;

    cda_in_if  dates_if ();
    cda_out_if shifted_if ();

    calendar_date_add dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .dates   (dates_if),
        .shifted (shifted_if)
    );

    date_res_t expected_dates[$];
    int        error_count  = 0;
    bit        src_idle_on  = 1'b0;
    bit        sink_idle_on = 1'b0;
    logic      sink_hold;
    event      start_long_stall;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Leap rule as written, also for year zero and negative years
    function automatic logic leap_year(input int yr);
        return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
    endfunction

    function automatic int month_length(input int yr, input int mon);
        if (mon == MONTH_FEB)
        begin
            return leap_year(yr) ? 29 : 28;
        end
        if (mon == MONTH_APR || mon == MONTH_JUN || mon == MONTH_SEP || mon == MONTH_NOV)
        begin
            return 30;
        end
        return 31;
    endfunction

    // Predicted shifted date for one request word
    function automatic date_res_t shift_date(input date_req_t r);
        date_res_t res;
        int        yr;
        int        mon;
        int        dom;
        int        dd;
        int        t;
        int        q;
        yr  = int'(r.start_year);
        mon = int'(r.start_month);
        dom = int'(r.start_day);
        dd  = int'(r.add_days);
        if (dom < 1)
        begin
            dom = 1;
        end
        // Add years and months, floor-divide the month into the year
        yr = yr + int'(r.add_years);
        t  = mon + int'(r.add_months) - 1;
        q  = (t >= 0) ? t / MONTH_SPAN : -((-t + MONTH_SPAN - 1) / MONTH_SPAN);
        yr  = yr + q;
        mon = t - MONTH_SPAN * q + 1;
        // Clamp the day to the new month
        if (dom > month_length(yr, mon))
        begin
            dom = month_length(yr, mon);
        end
        dom = dom + dd;
        // Strip whole 400-year cycles
        while (dom > CYCLE_DAYS)
        begin
            dom = dom - CYCLE_DAYS;
            yr  = yr + CYCLE_YEARS;
        end
        while (dom <= -CYCLE_DAYS)
        begin
            dom = dom + CYCLE_DAYS;
            yr  = yr - CYCLE_YEARS;
        end
        // Walk the remaining days one month at a time
        if (dd > 0)
        begin
            while (dom > month_length(yr, mon))
            begin
                dom = dom - month_length(yr, mon);
                if (mon == MONTH_DEC)
                begin
                    mon = MONTH_JAN;
                    yr  = yr + 1;
                end
                else
                begin
                    mon = mon + 1;
                end
            end
        end
        else if (dd < 0)
        begin
            while (dom <= 0)
            begin
                if (mon == MONTH_JAN)
                begin
                    mon = MONTH_DEC;
                    yr  = yr - 1;
                end
                else
                begin
                    mon = mon - 1;
                end
                dom = dom + month_length(yr, mon);
            end
        end
        // Saturate outside 1..9999
        if (yr > YEAR_MAX)
        begin
            res.result_year  = YEAR_BITS'(YEAR_MAX);
            res.result_month = MONTH_DEC;
            res.result_day   = DAY_BITS'(31);
            res.out_of_range = 1'b1;
        end
        else if (yr < 1)
        begin
            res.result_year  = YEAR_BITS'(1);
            res.result_month = MONTH_JAN;
            res.result_day   = DAY_BITS'(1);
            res.out_of_range = 1'b1;
        end
        else
        begin
            res.result_year  = YEAR_BITS'(yr);
            res.result_month = MONTH_BITS'(mon);
            res.result_day   = DAY_BITS'(dom);
            res.out_of_range = 1'b0;
        end
        return res;
    endfunction

    function automatic date_req_t make_date_req(input int yr, input int mon, input int dom,
                                                input int dy, input int dm, input int dd);
        date_req_t r;
        r.start_year  = YEAR_BITS'(yr);
        r.start_month = MONTH_BITS'(mon);
        r.start_day   = DAY_BITS'(dom);
        r.add_years   = ADD_YEAR_BITS'(dy);
        r.add_months  = ADD_MONTH_BITS'(dm);
        r.add_days    = DAY_OFFSET_BITS'(dd);
        return r;
    endfunction

    // Mostly plausible dates with modest offsets, some raw field bits;
    // day offsets are kept short most of the time since the walk is slow
    function automatic date_req_t random_date();
        date_req_t r;
        int        sel;
        sel = $urandom_range(0, 99);
        if (sel < 85)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                r.start_year = ($urandom_range(0, 1) == 0) ?
                               YEAR_BITS'($urandom_range(1, 40)) :
                               YEAR_BITS'($urandom_range(YEAR_MAX - 40, YEAR_MAX));
            end
            else
            begin
                r.start_year = YEAR_BITS'($urandom_range(1, YEAR_MAX));
            end
            r.start_month = MONTH_BITS'($urandom_range(1, 12));
            r.start_day   = DAY_BITS'($urandom_range(1, 31));
            r.add_years   = ADD_YEAR_BITS'(int'($urandom_range(0, 60)) - 30);
            r.add_months  = ADD_MONTH_BITS'(int'($urandom_range(0, 72)) - 36);
        end
        else
        begin
            r.start_year  = YEAR_BITS'($urandom());
            r.start_month = MONTH_BITS'($urandom());
            r.start_day   = DAY_BITS'($urandom());
            r.add_years   = ADD_YEAR_BITS'($urandom());
            r.add_months  = ADD_MONTH_BITS'($urandom());
        end
        sel = $urandom_range(0, 99);
        if (sel < 70)
        begin
            r.add_days = DAY_OFFSET_BITS'(int'($urandom_range(0, 800)) - 400);
        end
        else if (sel < 95)
        begin
            r.add_days = DAY_OFFSET_BITS'(int'($urandom_range(0, 6000)) - 3000);
        end
        else
        begin
            r.add_days = DAY_OFFSET_BITS'($urandom());
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("ERROR @%0t: %s", $time, what);
        end
    endtask

    // Offer one request word, hold it until it is taken, then record
    // the predicted result
    task automatic send_date(input date_req_t r);
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            dates_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        dates_if.valid       <= 1'b1;
        dates_if.start_year  <= r.start_year;
        dates_if.start_month <= r.start_month;
        dates_if.start_day   <= r.start_day;
        dates_if.add_years   <= r.add_years;
        dates_if.add_months  <= r.add_months;
        dates_if.add_days    <= r.add_days;
        @(posedge clk);
        while (dates_if.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        expected_dates.push_back(shift_date(r));
    endtask

    task automatic test_calendar_corners();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        // Leap rule and day clamp
        send_date(make_date_req(2024, 1, 31, 0, 1, 0));
        send_date(make_date_req(1900, 2, 28, 0, 0, 1));
        send_date(make_date_req(2000, 2, 28, 0, 0, 1));
        send_date(make_date_req(2023, 3, 31, 0, -1, 0));
        send_date(make_date_req(2021, 4, 31, 0, 0, 0));
        // Year carry and borrow during the day walk
        send_date(make_date_req(2023, 12, 31, 0, 0, 1));
        send_date(make_date_req(2024, 1, 1, 0, 0, -1));
        // Month outside 1..12, day zero
        send_date(make_date_req(2020, 0, 15, 0, 0, 0));
        send_date(make_date_req(2020, 13, 15, 0, 0, 0));
        send_date(make_date_req(2020, 15, 31, 0, 0, 0));
        send_date(make_date_req(2021, 6, 0, 0, 0, 0));
        // Start year outside 1..9999, year zero and negative years on the way
        send_date(make_date_req(0, 6, 1, 0, 0, 0));
        send_date(make_date_req(16383, 1, 1, -16000, 0, 0));
        send_date(make_date_req(5, 2, 29, -5, 0, 0));
        send_date(make_date_req(3, 3, 1, -10, 0, 4000));
        // Saturation at both ends
        send_date(make_date_req(9999, 12, 31, 0, 0, 1));
        send_date(make_date_req(1, 1, 1, 0, 0, -1));
        // Field extremes
        send_date(make_date_req(1, 1, 1, 16383, 1023, 65535));
        send_date(make_date_req(16383, 12, 31, -16384, -1024, -65536));
        send_date(make_date_req(5000, 7, 15, 0, 1023, 0));
        send_date(make_date_req(5000, 7, 15, 0, -1024, 0));
        send_date(make_date_req(5000, 7, 15, 0, 0, 65535));
        send_date(make_date_req(5000, 7, 15, 0, 0, -65536));
        send_date(make_date_req(2024, 5, 20, 0, 0, 0));
    endtask

    // Block the result side and keep offering words until the input stalls
    task automatic test_output_stall();
        -> start_long_stall;
        repeat (8)
        begin
            send_date(make_date_req($urandom_range(1, YEAR_MAX), $urandom_range(1, 12),
                                    $urandom_range(1, 31), 0, 0,
                                    int'($urandom_range(0, 60)) - 30));
        end
    endtask

    task automatic test_random_traffic();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        repeat (RANDOM_WORDS)
        begin
            send_date(random_date());
        end
    endtask

    task automatic test_steady_stream();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (STEADY_WORDS)
        begin
            send_date(random_date());
        end
    endtask

    // Long hold-off on the result side, counted here
    initial
    begin : long_stall
        sink_hold <= 1'b0;
        forever
        begin
            @(start_long_stall);
            sink_hold <= 1'b1;
            repeat (LONG_STALL_CYCLES) @(posedge clk);
            sink_hold <= 1'b0;
        end
    end

    // Drive ready on the result side, with random idle bursts
    initial
    begin : result_ready
        int gap;
        shifted_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || sink_hold)
            begin
                shifted_if.ready <= 1'b0;
            end
            else if (gap > 0)
            begin
                gap--;
                shifted_if.ready <= 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 17) - 1;
                shifted_if.ready <= 1'b0;
            end
            else
            begin
                shifted_if.ready <= 1'b1;
            end
        end
    end

    // Check each accepted result word against the oldest prediction
    always @(posedge clk)
    begin : result_check
        date_res_t want;
        if (rst_n && shifted_if.valid === 1'b1 && shifted_if.ready === 1'b1)
        begin
            if (expected_dates.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result word %0d-%0d-%0d flag %0b",
                                          shifted_if.result_year, shifted_if.result_month,
                                          shifted_if.result_day, shifted_if.out_of_range));
            end
            else
            begin
                want = expected_dates.pop_front();
                if (shifted_if.result_year !== want.result_year)
                begin
                    report_mismatch($sformatf("result_year %0d, expected %0d",
                                              shifted_if.result_year, want.result_year));
                end
                if (shifted_if.result_month !== want.result_month)
                begin
                    report_mismatch($sformatf("result_month %0d, expected %0d",
                                              shifted_if.result_month, want.result_month));
                end
                if (shifted_if.result_day !== want.result_day)
                begin
                    report_mismatch($sformatf("result_day %0d, expected %0d",
                                              shifted_if.result_day, want.result_day));
                end
                if (shifted_if.out_of_range !== want.out_of_range)
                begin
                    report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                              shifted_if.out_of_range, want.out_of_range));
                end
            end
        end
    end

    // Run limit
    initial
    begin : run_limit
        #(LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // Main sequence
    initial
    begin : main_seq
        rst_n                <= 1'b0;
        dates_if.valid       <= 1'b0;
        dates_if.start_year  <= '0;
        dates_if.start_month <= '0;
        dates_if.start_day   <= '0;
        dates_if.add_years   <= '0;
        dates_if.add_months  <= '0;
        dates_if.add_days    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_calendar_corners();
        test_output_stall();
        test_random_traffic();
        test_steady_stream();

        // Drain, then watch for stray words
        dates_if.valid <= 1'b0;
        while (expected_dates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
